// File: design/pressure_temp_compensation_assert.svh
// Assertion macros for the pressure/temperature compensation block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// Check a property at every clock edge outside reset
`define PTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset
`define PTC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: design/ptc_pkg.sv
// Shared types, constants and the step program of the compensation block.
// No dependencies; imported by every module of the block.
package ptc_pkg;

  // Sample and fixed-point widths
  localparam int RAW_BITS  = 24;
  localparam int FRAC_BITS = 24;
  localparam int OUT_SHIFT = 8;
  localparam int DW        = 64;
  localparam int SF_W      = 24;
  localparam int DIV_W     = RAW_BITS + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int PC_W      = 4;

  // Coefficient widths
  localparam int C0_W  = 12;
  localparam int C00_W = 20;
  localparam int C16_W = 16;
  localparam int WGT_W = 17;

  // Register file
  localparam int REG_COUNT  = 7;
  localparam int REG_STRIDE = 3;
  localparam int APB_AW     = $clog2(REG_COUNT * 8);
  localparam int APB_DW     = 64;

  localparam logic [SF_W-1:0]  SF_RESET  = SF_W'(1);
  localparam logic [WGT_W-1:0] WGT_RESET = WGT_W'(32768);

  typedef enum logic [2:0] {
    REG_C0_C1     = 3'd0,
    REG_C00_C10   = 3'd1,
    REG_C01_C21   = 3'd2,
    REG_C30       = 3'd3,
    REG_TEMP_SF   = 3'd4,
    REG_PRES_SF   = 3'd5,
    REG_OFF_WGT   = 3'd6
  } reg_idx_e;

  typedef enum logic {
    OP_TEMP = 1'b0,
    OP_PRES = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } state_e;

  // Rounding shift applied to a product
  typedef enum logic [1:0] {
    SH_NONE,
    SH_FRAC,
    SH_OUT
  } shift_e;

  typedef enum logic [2:0] {
    A_PSC,
    A_TSC,
    A_H,
    A_G,
    A_C0
  } a_sel_e;

  typedef enum logic [2:0] {
    B_WGT,
    B_C1,
    B_C30,
    B_H,
    B_C21,
    B_G,
    B_C01,
    B_ONE
  } b_sel_e;

  typedef enum logic [2:0] {
    ADD_ZERO,
    ADD_H,
    ADD_C20,
    ADD_C10,
    ADD_C00,
    ADD_C11
  } add_sel_e;

  typedef enum logic {
    DST_H,
    DST_G
  } dst_e;

  typedef struct packed {
    a_sel_e   a;
    b_sel_e   b;
    shift_e   sh;
    add_sel_e add;
    dst_e     dst;
    logic     last;
  } uop_t;

  // Decoded coefficient and scale registers
  typedef struct packed {
    logic [C0_W-1:0]  c0;
    logic [C0_W-1:0]  c1;
    logic [C00_W-1:0] c00;
    logic [C00_W-1:0] c10;
    logic [C16_W-1:0] c01;
    logic [C16_W-1:0] c11;
    logic [C16_W-1:0] c20;
    logic [C16_W-1:0] c21;
    logic [C16_W-1:0] c30;
    logic [SF_W-1:0]  tsf;
    logic [SF_W-1:0]  psf;
    logic [WGT_W-1:0] wgt;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [SF_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    shift_e        sh;
  } mul_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] res;
    logic          sat;
  } mul_rsp_t;

  localparam uop_t UOP_FINAL = '{a: A_H, b: B_ONE, sh: SH_OUT, add: ADD_ZERO,
                                 dst: DST_H, last: 1'b1};

  // Step program: each step is one product plus an optional saturating add
  function automatic uop_t get_uop(input op_e op, input logic [PC_W-1:0] pc);
    uop_t u;
    u = UOP_FINAL;
    if (op == OP_TEMP) begin
      case (pc)
        4'd0: u = '{a: A_C0,  b: B_WGT, sh: SH_NONE, add: ADD_ZERO, dst: DST_H, last: 1'b0};
        4'd1: u = '{a: A_TSC, b: B_C1,  sh: SH_NONE, add: ADD_H,    dst: DST_H, last: 1'b0};
        default: u = UOP_FINAL;
      endcase
    end else begin
      case (pc)
        4'd0: u = '{a: A_PSC, b: B_C30, sh: SH_NONE, add: ADD_C20,  dst: DST_H, last: 1'b0};
        4'd1: u = '{a: A_PSC, b: B_H,   sh: SH_FRAC, add: ADD_C10,  dst: DST_H, last: 1'b0};
        4'd2: u = '{a: A_PSC, b: B_H,   sh: SH_FRAC, add: ADD_C00,  dst: DST_H, last: 1'b0};
        4'd3: u = '{a: A_PSC, b: B_C21, sh: SH_NONE, add: ADD_C11,  dst: DST_G, last: 1'b0};
        4'd4: u = '{a: A_PSC, b: B_G,   sh: SH_FRAC, add: ADD_ZERO, dst: DST_G, last: 1'b0};
        4'd5: u = '{a: A_TSC, b: B_G,   sh: SH_FRAC, add: ADD_ZERO, dst: DST_G, last: 1'b0};
        4'd6: u = '{a: A_TSC, b: B_C01, sh: SH_NONE, add: ADD_H,    dst: DST_H, last: 1'b0};
        4'd7: u = '{a: A_G,   b: B_ONE, sh: SH_NONE, add: ADD_H,    dst: DST_H, last: 1'b0};
        default: u = UOP_FINAL;
      endcase
    end
    return u;
  endfunction

endpackage

// File: design/ptc_cfg.sv
// APB register file holding the compensation coefficients and scale factors.
// Depends on ptc_pkg for widths, register indexes and the decoded cfg_t.
module ptc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptc_pkg::APB_AW-1:0]   paddr,
  input  logic [ptc_pkg::APB_DW-1:0]   pwdata,
  output logic [ptc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output ptc_pkg::cfg_t                cfg_o
);
  import ptc_pkg::*;

  logic [2*C0_W-1:0]  c0_c1_q;
  logic [2*C00_W-1:0] c00_c10_q;
  logic [4*C16_W-1:0] c01_c21_q;
  logic [C16_W-1:0]   c30_q;
  logic [SF_W-1:0]    tsf_q;
  logic [SF_W-1:0]    psf_q;
  logic [WGT_W-1:0]   wgt_q;
  reg_idx_e           idx;
  logic               wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:REG_STRIDE]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_c1_q   <= '0;
      c00_c10_q <= '0;
      c01_c21_q <= '0;
      c30_q     <= '0;
      tsf_q     <= SF_RESET;
      psf_q     <= SF_RESET;
      wgt_q     <= WGT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_C0_C1:   c0_c1_q   <= pwdata[2*C0_W-1:0];
        REG_C00_C10: c00_c10_q <= pwdata[2*C00_W-1:0];
        REG_C01_C21: c01_c21_q <= pwdata[4*C16_W-1:0];
        REG_C30:     c30_q     <= pwdata[C16_W-1:0];
        REG_TEMP_SF: tsf_q     <= pwdata[SF_W-1:0];
        REG_PRES_SF: psf_q     <= pwdata[SF_W-1:0];
        REG_OFF_WGT: wgt_q     <= pwdata[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_C0_C1:   prdata = APB_DW'(c0_c1_q);
      REG_C00_C10: prdata = APB_DW'(c00_c10_q);
      REG_C01_C21: prdata = APB_DW'(c01_c21_q);
      REG_C30:     prdata = APB_DW'(c30_q);
      REG_TEMP_SF: prdata = APB_DW'(tsf_q);
      REG_PRES_SF: prdata = APB_DW'(psf_q);
      REG_OFF_WGT: prdata = APB_DW'(wgt_q);
      default:     prdata = '0;
    endcase
  end

  // Split packed registers into coefficients
  always_comb begin
    cfg_o.c0  = c0_c1_q[2*C0_W-1:C0_W];
    cfg_o.c1  = c0_c1_q[C0_W-1:0];
    cfg_o.c00 = c00_c10_q[2*C00_W-1:C00_W];
    cfg_o.c10 = c00_c10_q[C00_W-1:0];
    cfg_o.c01 = c01_c21_q[4*C16_W-1:3*C16_W];
    cfg_o.c11 = c01_c21_q[3*C16_W-1:2*C16_W];
    cfg_o.c20 = c01_c21_q[2*C16_W-1:C16_W];
    cfg_o.c21 = c01_c21_q[C16_W-1:0];
    cfg_o.c30 = c30_q;
    cfg_o.tsf = tsf_q;
    cfg_o.psf = psf_q;
    cfg_o.wgt = wgt_q;
  end

endmodule

// File: design/ptc_div.sv
// Restoring divider, one quotient bit per cycle, for the sample scaling.
// Depends on ptc_pkg for widths and the request/response structs.
module ptc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptc_pkg::div_req_t req_i,
  output ptc_pkg::div_rsp_t rsp_o
);
  import ptc_pkg::*;

  logic [DIV_W-1:0]     quo_q;
  logic [SF_W-1:0]      rem_q;
  logic [SF_W-1:0]      dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [SF_W:0]        trial;
  logic [SF_W:0]        diff;
  logic                 qbit;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dsr_q};
    qbit  = !diff[SF_W];
  end

  // Sequence the bit steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend through, collecting quotient bits; zero divisor acts as one
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= (req_i.divisor == '0) ? SF_W'(1) : req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], qbit};
      rem_q <= qbit ? diff[SF_W-1:0] : trial[SF_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// File: design/ptc_mul.sv
// Shared multiplier: 64x64 sign-magnitude product from four 32x32 passes,
// then round-half-away, scale back and saturate. Depends on ptc_pkg.
module ptc_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptc_pkg::mul_req_t req_i,
  output ptc_pkg::mul_rsp_t rsp_o
);
  import ptc_pkg::*;

  localparam int HW = DW / 2;
  localparam int PW = 2 * DW;
  localparam logic [2:0] STEP_ROUND = 3'd5;
  localparam logic [2:0] STEP_FINAL = 3'd6;

  logic [DW-1:0]  ua_q;
  logic [DW-1:0]  ub_q;
  logic           neg_q;
  shift_e         sh_q;
  logic [2:0]     step_q;
  logic           busy_q;
  logic           done_q;
  logic [DW-1:0]  prod_q;
  logic [PW-1:0]  acc_q;
  logic [DW-1:0]  mag_q;
  logic           over_q;
  logic [DW-1:0]  res_q;
  logic           sat_q;
  logic [HW-1:0]  opa;
  logic [HW-1:0]  opb;
  logic [DW-1:0]  prod_d;
  logic [PW-1:0]  acc_add;
  logic [PW-1:0]  rnd;
  logic [PW-1:0]  rounded;
  logic [PW-1:0]  shifted;
  logic [DW-1:0]  limit;
  logic [DW-1:0]  mag_clip;
  logic           clip;

  // Pick the 32-bit halves for this pass
  always_comb begin
    opa    = step_q[1] ? ua_q[DW-1:HW] : ua_q[HW-1:0];
    opb    = step_q[0] ? ub_q[DW-1:HW] : ub_q[HW-1:0];
    prod_d = DW'(opa) * DW'(opb);
  end

  // Align the previous pass's product
  always_comb begin
    case (step_q)
      3'd1:       acc_add = PW'(prod_q);
      3'd2, 3'd3: acc_add = PW'(prod_q) << HW;
      3'd4:       acc_add = PW'(prod_q) << DW;
      default:    acc_add = '0;
    endcase
  end

  // Round to nearest, ties away, then drop the fraction bits
  always_comb begin
    case (sh_q)
      SH_FRAC: rnd = PW'(1) << (FRAC_BITS - 1);
      SH_OUT:  rnd = PW'(1) << (OUT_SHIFT - 1);
      default: rnd = '0;
    endcase
    rounded = acc_q + rnd;
    case (sh_q)
      SH_FRAC: shifted = rounded >> FRAC_BITS;
      SH_OUT:  shifted = rounded >> OUT_SHIFT;
      default: shifted = rounded;
    endcase
  end

  // Clip to the signed range
  always_comb begin
    limit    = neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    clip     = over_q || (mag_q > limit);
    mag_clip = clip ? limit : mag_q;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == STEP_FINAL) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ua_q  <= req_i.a[DW-1] ? (~req_i.a + DW'(1)) : req_i.a;
      ub_q  <= req_i.b[DW-1] ? (~req_i.b + DW'(1)) : req_i.b;
      neg_q <= req_i.a[DW-1] ^ req_i.b[DW-1];
      sh_q  <= req_i.sh;
      acc_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_d;
      acc_q  <= acc_q + acc_add;
      if (step_q == STEP_ROUND) begin
        over_q <= |shifted[PW-1:DW];
        mag_q  <= shifted[DW-1:0];
      end
      if (step_q == STEP_FINAL) begin
        res_q <= neg_q ? (~mag_clip + DW'(1)) : mag_clip;
        sat_q <= clip;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;
  assign rsp_o.sat  = sat_q;

endmodule

// File: design/pressure_temp_compensation.sv
// Barometric sensor compensation: each transfer carries one signed raw sample marked as
// temperature (op 0) or pressure (op 1); the block divides it by the scale factor of its kind
// into signed Q24.24, stores the scaled temperature, evaluates the calibration polynomial on a
// shared 32x32 multiplier and returns one result, signed with 16 fraction bits, with a flag
// that is set when any product or sum clipped. Registers sit on the APB port at 8*index:
// c0/c1, c00/c10, c01/c11/c20/c21, c30, temperature scale, pressure scale, offset weight.
// An item passes through the one-bit-per-cycle divider and then through its step program:
// 3 steps for temperature and 9 for pressure. Each step is a pass through the shared multiplier
// plus issue and write-back. Input stalls until the result is loaded into the output register,
// and the stored scaled temperature is zero after reset. Depends on ptc_pkg, ptc_cfg, ptc_div,
// ptc_mul and the assertion macro header.
`include "pressure_temp_compensation_assert.svh"

module pressure_temp_compensation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ptc_pkg::APB_AW-1:0]         paddr,
  input  logic [ptc_pkg::APB_DW-1:0]         pwdata,
  output logic [ptc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic signed [ptc_pkg::RAW_BITS-1:0] raw_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [ptc_pkg::DW-1:0]      comp_value_o,
  output logic                               saturated_o
);
  import ptc_pkg::*;

  cfg_t              cfg;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;
  uop_t              uop;

  state_e            state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic              out_valid_q, out_valid_d;
  logic [DIV_W-1:0]  last_temp_q;
  op_e               op_q;
  logic              neg_q;
  logic              sat_q;
  logic [DIV_W-1:0]  scaled_q;
  logic [DW-1:0]     h_q;
  logic [DW-1:0]     g_q;
  logic signed [DW-1:0] comp_q;
  logic              outsat_q;

  logic              in_xfer;
  logic              div_load;
  logic              mul_start;
  logic              wr_step;
  logic              out_load;
  logic [RAW_BITS-1:0] raw_mag;
  logic [DIV_W-1:0]  scaled_d;
  logic [DW-1:0]     addend;
  logic [DW:0]       sum_ext;
  logic              add_ovf;
  logic [DW-1:0]     add_res;

  ptc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ptc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && (state_q == ST_IDLE);
  assign uop        = get_uop(op_q, pc_q);

  // Start the divider on the magnitude of the sample, shifted to Q24
  always_comb begin
    raw_mag          = raw_sample_i[RAW_BITS-1] ?
                       ($unsigned(~raw_sample_i) + RAW_BITS'(1)) : $unsigned(raw_sample_i);
    div_req.start    = in_xfer;
    div_req.dividend = {raw_mag, {FRAC_BITS{1'b0}}};
    div_req.divisor  = (op_e'(op_i) == OP_TEMP) ? cfg.tsf : cfg.psf;
    scaled_d         = neg_q ? (~div_rsp.quo + DIV_W'(1)) : div_rsp.quo;
  end

  // Multiplier operands for the current step
  always_comb begin
    mul_req.start = mul_start;
    mul_req.sh    = uop.sh;
    case (uop.a)
      A_PSC:   mul_req.a = DW'($signed(scaled_q));
      A_TSC:   mul_req.a = DW'($signed(last_temp_q));
      A_H:     mul_req.a = h_q;
      A_G:     mul_req.a = g_q;
      A_C0:    mul_req.a = DW'($signed(cfg.c0));
      default: mul_req.a = '0;
    endcase
    case (uop.b)
      B_WGT:   mul_req.b = DW'({cfg.wgt, {OUT_SHIFT{1'b0}}});
      B_C1:    mul_req.b = DW'($signed(cfg.c1));
      B_C30:   mul_req.b = DW'($signed(cfg.c30));
      B_H:     mul_req.b = h_q;
      B_C21:   mul_req.b = DW'($signed(cfg.c21));
      B_G:     mul_req.b = g_q;
      B_C01:   mul_req.b = DW'($signed(cfg.c01));
      B_ONE:   mul_req.b = DW'(1);
      default: mul_req.b = '0;
    endcase
  end

  // Saturating add of the product and the step's addend
  always_comb begin
    case (uop.add)
      ADD_H:   addend = h_q;
      ADD_C20: addend = DW'($signed({cfg.c20, {FRAC_BITS{1'b0}}}));
      ADD_C10: addend = DW'($signed({cfg.c10, {FRAC_BITS{1'b0}}}));
      ADD_C00: addend = DW'($signed({cfg.c00, {FRAC_BITS{1'b0}}}));
      ADD_C11: addend = DW'($signed({cfg.c11, {FRAC_BITS{1'b0}}}));
      default: addend = '0;
    endcase
    sum_ext = {addend[DW-1], addend} + {mul_rsp.res[DW-1], mul_rsp.res};
    add_ovf = sum_ext[DW] ^ sum_ext[DW-1];
    if (add_ovf) begin
      add_res = sum_ext[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      add_res = sum_ext[DW-1:0];
    end
  end

  // Sequencer: divide, then run the step program, then hand off the result
  always_comb begin
    state_d   = state_q;
    pc_d      = pc_q;
    div_load  = 1'b0;
    mul_start = 1'b0;
    wr_step   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          div_load = 1'b1;
          pc_d     = '0;
          state_d  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp.done) begin
          wr_step = 1'b1;
          if (uop.last) begin
            state_d = ST_OUT;
          end else begin
            pc_d    = pc_q + PC_W'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  // Control state and the stored scaled temperature
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
      last_temp_q <= '0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (div_load && (op_q == OP_TEMP)) begin
        last_temp_q <= scaled_d;
      end
    end
  end

  // Working registers and the output register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_e'(op_i);
      neg_q <= raw_sample_i[RAW_BITS-1];
      sat_q <= 1'b0;
    end
    if (div_load) begin
      scaled_q <= scaled_d;
    end
    if (wr_step) begin
      sat_q <= sat_q | mul_rsp.sat | add_ovf;
      case (uop.dst)
        DST_G:   g_q <= add_res;
        default: h_q <= add_res;
      endcase
    end
    if (out_load) begin
      comp_q   <= $signed(h_q);
      outsat_q <= sat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign comp_value_o = comp_q;
  assign saturated_o  = outsat_q;

  // Unit handshakes line up with the sequencer
  `PTC_ASSERT(a_mul_done_in_wait, mul_rsp.done |-> state_q == ST_WAIT, "multiplier done outside wait")
  `PTC_ASSERT(a_div_done_in_div, div_rsp.done |-> state_q == ST_DIV, "divider done outside divide")
  `PTC_ASSERT(a_temp_hold, state_q == ST_WAIT |=> $stable(last_temp_q), "scaled temp changed mid-item")
  `PTC_NEVER(a_no_overwrite, out_load && out_valid_q && out_stall_i, "pending result overwritten")

endmodule
